// ===== hw/rtl/mie_pkg.sv =====
// Package with shared widths, status codes and payload types for the modular inverse block.
`timescale 1ns / 1ps
package mie_pkg;

   localparam int unsigned WIDTH      = 31;
   localparam int unsigned COEF_WIDTH = WIDTH + 2;
   localparam int unsigned CNT_WIDTH  = $clog2(WIDTH);

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_INVERSE = 2'd1,
      STATUS_ZERO_MOD   = 2'd2
   } status_type;

   typedef struct packed {
      logic [WIDTH-1:0] value;
      logic [WIDTH-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [WIDTH-1:0] inverse;
      status_type       status;
   } rsp_type;

   typedef struct packed {
      logic [WIDTH-1:0]      rem;
      logic [COEF_WIDTH-1:0] prod;
   } div_step_type;

endpackage

// ===== hw/rtl/mie_div_step.sv =====
// One restoring division step that also accumulates quotient times coefficient.
`timescale 1ns / 1ps
module mie_div_step (
   input  logic [mie_pkg::WIDTH-1:0]      rem,
   input  logic                           dvd_msb,
   input  logic [mie_pkg::WIDTH-1:0]      divisor,
   input  logic [mie_pkg::COEF_WIDTH-1:0] prod,
   input  logic [mie_pkg::COEF_WIDTH-1:0] coef,
   output mie_pkg::div_step_type          step
);
   import mie_pkg::*;

   logic [WIDTH:0]   shifted;
   logic [WIDTH+1:0] diff;
   logic             qbit;

   assign shifted = {rem, dvd_msb};
   assign diff    = {1'b0, shifted} - {2'b00, divisor};
   assign qbit    = ~diff[WIDTH+1];

   assign step.rem  = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
   assign step.prod = {prod[COEF_WIDTH-2:0], 1'b0} + (qbit ? coef : '0);

endmodule

// ===== hw/rtl/modular_inverse_euclid_top.sv =====
// Top level of the modular inverse block using an iterative extended Euclidean algorithm.
//
//   Channel   Direction   Payload    Handshake
//   req_      in          req_type   req_valid / req_ready
//   rsp_      out         rsp_type   rsp_valid / rsp_ready
//
// Each Euclid iteration runs the one shared restoring division step once per dividend bit,
// then swaps remainders and updates the coefficient in ST_UPDATE.
// A zero modulus is answered from ST_ERR without any division steps.
// Reset clears the sequencer and the response valid; no clearing pass is needed.
// The block takes a new request only when idle; a held response stalls the final step.
`timescale 1ns / 1ps
module modular_inverse_euclid_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mie_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mie_pkg::rsp_type rsp_data
);
   import mie_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_UPDATE,
      ST_FOLD,
      ST_ERR
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [WIDTH-1:0]      dvd_ff, dvd_in;
   logic [WIDTH-1:0]      rem_ff, rem_in;
   logic [WIDTH-1:0]      r1_ff, r1_in;
   logic [WIDTH-1:0]      mod_ff, mod_in;
   logic [COEF_WIDTH-1:0] s0_ff, s0_in;
   logic [COEF_WIDTH-1:0] s1_ff, s1_in;
   logic [COEF_WIDTH-1:0] prod_ff, prod_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   div_step_type          step;
   logic                  out_free;
   logic [COEF_WIDTH-1:0] mod_ext;

   mie_div_step u_div_step (
      .rem     (rem_ff),
      .dvd_msb (dvd_ff[WIDTH-1]),
      .divisor (r1_ff),
      .prod    (prod_ff),
      .coef    (s1_ff),
      .step    (step)
   );

   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign mod_ext  = {2'b00, mod_ff};

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      r1_in        = r1_ff;
      mod_in       = mod_ff;
      s0_in        = s0_ff;
      s1_in        = s1_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dvd_in  = req_data.value;
               r1_in   = req_data.modulus;
               mod_in  = req_data.modulus;
               s0_in   = COEF_WIDTH'(1);
               s1_in   = '0;
               rem_in  = '0;
               prod_in = '0;
               cnt_in  = CNT_WIDTH'(WIDTH - 1);
               state_in = (req_data.modulus == '0) ? ST_ERR : ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = step.rem;
            prod_in = step.prod;
            dvd_in  = {dvd_ff[WIDTH-2:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            dvd_in  = r1_ff;
            r1_in   = rem_ff;
            s0_in   = s1_ff;
            s1_in   = s0_ff - prod_ff;
            rem_in  = '0;
            prod_in = '0;
            cnt_in  = CNT_WIDTH'(WIDTH - 1);
            state_in = (rem_ff == '0) ? ST_FOLD : ST_DIV;
         end
         ST_FOLD: begin
            if (dvd_ff > WIDTH'(1)) begin
               if (out_free) begin
                  rsp_valid_in        = 1'b1;
                  rsp_data_in.inverse = '0;
                  rsp_data_in.status  = STATUS_NO_INVERSE;
                  state_in            = ST_IDLE;
               end
            end else if (s0_ff[COEF_WIDTH-1]) begin
               s0_in = s0_ff + mod_ext;
            end else if (s0_ff >= mod_ext) begin
               s0_in = s0_ff - mod_ext;
            end else if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.inverse = s0_ff[WIDTH-1:0];
               rsp_data_in.status  = STATUS_OK;
               state_in            = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.inverse = '0;
               rsp_data_in.status  = STATUS_ZERO_MOD;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      r1_ff       <= r1_in;
      mod_ff      <= mod_in;
      s0_ff       <= s0_in;
      s1_ff       <= s1_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/mie_checker.sv =====
// Port-level checker for the modular inverse block and its bind to the top level.
`timescale 1ns / 1ps
module mie_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mie_pkg::rsp_type rsp_data
);
   import mie_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Response changed or dropped while stalled.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |-> (rsp_data.inverse == '0))
      else $error("Nonzero inverse reported with an error status.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Block stayed ready after accepting a request.");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("Response appeared without a request in progress.");

endmodule

bind modular_inverse_euclid_top mie_checker u_mie_checker (.*);
